### hw/rtl/rgbmsd_pkg.sv
`timescale 1ns / 1ps

package rgbmsd_pkg;

    // panel geometry
    localparam int PANEL_WIDTH  = 64;
    localparam int PANEL_HEIGHT = 32;
    localparam int SCAN_ROWS    = 16;

    localparam int COL_W      = 6;
    localparam int Y_W        = 5;
    localparam int ROW_W      = 4;
    localparam int LEVEL_W    = 8;
    localparam int COLOR_W    = 3;
    localparam int PERIOD_W   = 10;
    localparam int HALF_DEPTH = SCAN_ROWS * PANEL_WIDTH;
    localparam int HALF_AW    = ROW_W + COL_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(1000);
    localparam logic [LEVEL_W-1:0]  LEVEL_THRESHOLD = LEVEL_W'(127);

    // colour bit positions
    localparam int RED_BIT   = 0;
    localparam int GREEN_BIT = 1;
    localparam int BLUE_BIT  = 2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic pix_write;
        logic tick;
        logic scan_start;
        logic issue;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_hit;
        logic col_last;
        logic rd_is_last;
    } t_dp_status;

endpackage

### hw/rtl/rgbmsd_ram.sv
`timescale 1ns / 1ps

module rgbmsd_ram #(
    parameter int WIDTH = rgbmsd_pkg::COLOR_W,
    parameter int DEPTH = rgbmsd_pkg::HALF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/rgbmsd_ctrl.sv
`timescale 1ns / 1ps

module rgbmsd_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_mode,
    input  logic                   i_out_stall,
    input  rgbmsd_pkg::t_dp_status i_status,
    output rgbmsd_pkg::t_ctl_cmd   o_cmd,
    output logic                   o_in_stall,
    output logic                   o_out_valid
);

    import rgbmsd_pkg::*;

    t_state     r_state, n_state;
    logic       r_rd_valid, n_rd_valid;
    logic       r_out_valid, n_out_valid;
    logic       r_issue_done, n_issue_done;
    logic       advance;
    t_ctl_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_issue_done <= 1'b1;
        end else begin
            r_state      <= n_state;
            r_rd_valid   <= n_rd_valid;
            r_out_valid  <= n_out_valid;
            r_issue_done <= n_issue_done;
        end
    end

    // output slot free or being emptied this cycle
    assign advance = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_rd_valid   = r_rd_valid;
        n_out_valid  = r_out_valid;
        n_issue_done = r_issue_done;
        cmd          = '0;

        case (r_state)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (!i_mode) begin
                        cmd.pix_write = 1'b1;
                    end else begin
                        cmd.tick = 1'b1;
                        if (i_status.scan_hit) begin
                            cmd.scan_start = 1'b1;
                            n_issue_done   = 1'b0;
                            n_state        = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (advance && !r_issue_done) begin
                    cmd.issue = 1'b1;
                    if (i_status.col_last) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (advance && r_rd_valid && i_status.rd_is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // two-slot pipe: ram read data, then output register
        if (advance) begin
            cmd.load    = r_rd_valid;
            n_out_valid = r_rd_valid;
            n_rd_valid  = cmd.issue;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/rgbmsd_datapath.sv
`timescale 1ns / 1ps

module rgbmsd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rgbmsd_pkg::t_ctl_cmd                i_cmd,
    output rgbmsd_pkg::t_dp_status              o_status,
    input  logic                                i_cfg_wr_en,
    input  logic [rgbmsd_pkg::PERIOD_W-1:0]     i_cfg_wr_data,
    input  logic [rgbmsd_pkg::COL_W-1:0]        i_pixel_x,
    input  logic [rgbmsd_pkg::Y_W-1:0]          i_pixel_y,
    input  logic [rgbmsd_pkg::LEVEL_W-1:0]      i_red_level,
    input  logic [rgbmsd_pkg::LEVEL_W-1:0]      i_green_level,
    input  logic [rgbmsd_pkg::LEVEL_W-1:0]      i_blue_level,
    output logic [rgbmsd_pkg::COLOR_W-1:0]      o_top_rgb,
    output logic [rgbmsd_pkg::COLOR_W-1:0]      o_bottom_rgb,
    output logic [rgbmsd_pkg::COL_W-1:0]        o_column,
    output logic [rgbmsd_pkg::ROW_W-1:0]        o_row_address,
    output logic                                o_last
);

    import rgbmsd_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_tick, n_tick;
    logic [PERIOD_W-1:0] period_eff, tick_inc;
    logic [ROW_W-1:0]    r_scan_row;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    r_rd_col;
    logic [HALF_AW-1:0]  r_clr_addr;

    logic [COLOR_W-1:0]  pix_bits;
    logic [COLOR_W-1:0]  wdata;
    logic [HALF_AW-1:0]  waddr, raddr;
    logic                lower_half;
    logic                we_top, we_bot;
    logic [COLOR_W-1:0]  top_rdata, bot_rdata;

    logic [COLOR_W-1:0]  r_top_rgb, r_bottom_rgb;
    logic [COL_W-1:0]    r_column;
    logic [ROW_W-1:0]    r_row_address;
    logic                r_last;

    // row period register and tick counter
    assign period_eff = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign tick_inc   = r_tick + PERIOD_W'(1);
    assign n_tick     = (tick_inc >= period_eff) ? '0 : tick_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_tick     <= '0;
            r_scan_row <= '0;
            r_col      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (i_cmd.tick) begin
                r_tick <= n_tick;
            end
            if (i_cmd.scan_start) begin
                r_scan_row <= (r_scan_row == ROW_W'(SCAN_ROWS - 1)) ?
                              '0 : r_scan_row + ROW_W'(1);
                r_col      <= '0;
            end else if (i_cmd.issue) begin
                r_col <= r_col + COL_W'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + HALF_AW'(1);
            end
        end
    end

    // threshold the three levels
    always_comb begin
        pix_bits            = '0;
        pix_bits[RED_BIT]   = (i_red_level   > LEVEL_THRESHOLD);
        pix_bits[GREEN_BIT] = (i_green_level > LEVEL_THRESHOLD);
        pix_bits[BLUE_BIT]  = (i_blue_level  > LEVEL_THRESHOLD);
    end

    // rows at or beyond the scan count sit in the lower-half store
    assign lower_half = i_pixel_y[ROW_W];
    assign waddr = i_cmd.clr_step ? r_clr_addr : {i_pixel_y[ROW_W-1:0], i_pixel_x};
    assign wdata = i_cmd.clr_step ? '0 : pix_bits;
    assign we_top = i_cmd.clr_step || (i_cmd.pix_write && !lower_half);
    assign we_bot = i_cmd.clr_step || (i_cmd.pix_write && lower_half);
    assign raddr  = {r_scan_row, r_col};

    rgbmsd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (HALF_DEPTH)
    ) u_top_ram (
        .i_clk   (i_clk),
        .i_we    (we_top),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (raddr),
        .o_rdata (top_rdata)
    );

    rgbmsd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (HALF_DEPTH)
    ) u_bot_ram (
        .i_clk   (i_clk),
        .i_we    (we_bot),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (raddr),
        .o_rdata (bot_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_col <= r_col;
        end
        if (i_cmd.load) begin
            r_top_rgb     <= top_rdata;
            r_bottom_rgb  <= bot_rdata;
            r_column      <= r_rd_col;
            r_row_address <= r_scan_row;
            r_last        <= (r_rd_col == COL_W'(PANEL_WIDTH - 1));
        end
    end

    assign o_status.clr_done   = (r_clr_addr == HALF_AW'(HALF_DEPTH - 1));
    assign o_status.scan_hit   = (r_tick == '0);
    assign o_status.col_last   = (r_col == COL_W'(PANEL_WIDTH - 1));
    assign o_status.rd_is_last = (r_rd_col == COL_W'(PANEL_WIDTH - 1));

    assign o_top_rgb     = r_top_rgb;
    assign o_bottom_rgb  = r_bottom_rgb;
    assign o_column      = r_column;
    assign o_row_address = r_row_address;
    assign o_last        = r_last;

endmodule

### hw/rtl/rgb_matrix_scan_driver.sv
`timescale 1ns / 1ps

// scan driver for a 64x32 rgb led panel with 1/16 scan
// input channel (i_in_valid / o_in_stall): mode 0 writes one pixel, three
//   colour bits, a channel lit when its level is above 127; mode 1 is a
//   time tick. a pixel write does not stall the input.
// a tick that finds the tick counter at zero starts a row scan: the scan
//   row steps on, and 64 column transactions leave on the output channel
//   (o_out_valid / i_out_stall), the upper pixel and the pixel 16 rows
//   below, with o_last on the final column (blank, address, latch, unblank)
// columns pass from the ram read data into the output register, one column a
//   cycle while the receiver takes them; a scanning tick keeps the input stalled
//   until the final column is loaded for output; this rate is set by the single
//   read port of each half-panel store, one column a cycle
// no input is taken during a scan; a stall on the output freezes the
//   column reads and holds the output payload unchanged while it lasts
// i_cfg_wr_en / i_cfg_wr_data set the row period in ticks (zero acts as one)
// after reset both frame stores are cleared, one entry a cycle over all 1024
//   entries, with the input channel stalled; the period returns to 1000
//   and the scan row and tick counter to zero

module rgb_matrix_scan_driver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [rgbmsd_pkg::PERIOD_W-1:0] i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [rgbmsd_pkg::COL_W-1:0]    i_pixel_x,
    input  logic [rgbmsd_pkg::Y_W-1:0]      i_pixel_y,
    input  logic [rgbmsd_pkg::LEVEL_W-1:0]  i_red_level,
    input  logic [rgbmsd_pkg::LEVEL_W-1:0]  i_green_level,
    input  logic [rgbmsd_pkg::LEVEL_W-1:0]  i_blue_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rgbmsd_pkg::COLOR_W-1:0]  o_top_rgb,
    output logic [rgbmsd_pkg::COLOR_W-1:0]  o_bottom_rgb,
    output logic [rgbmsd_pkg::COL_W-1:0]    o_column,
    output logic [rgbmsd_pkg::ROW_W-1:0]    o_row_address,
    output logic                            o_last
);

    import rgbmsd_pkg::*;

    // command and status between controller and datapath
    t_ctl_cmd   cmd;
    t_dp_status status;

    rgbmsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rgbmsd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_red_level   (i_red_level),
        .i_green_level (i_green_level),
        .i_blue_level  (i_blue_level),
        .o_top_rgb     (o_top_rgb),
        .o_bottom_rgb  (o_bottom_rgb),
        .o_column      (o_column),
        .o_row_address (o_row_address),
        .o_last        (o_last)
    );

    // a scan, once started, locks out new input until it drains
    a_scan_locks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_start |=> o_in_stall)
        else $error("input not stalled after scan start");

    // the last marker only ever sits on the final column
    a_last_on_final_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_column == COL_W'(PANEL_WIDTH - 1)))
        else $error("last marker on wrong column");

    // no column read is issued past the final column
    a_no_issue_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.issue && status.col_last) |=> !cmd.issue)
        else $error("column read issued past end of row");

    // a column is moved to the output only while a scan is running
    a_load_needs_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> o_in_stall)
        else $error("output loaded outside a scan");

endmodule
